// ===== design/iou_motion_check_unit_macros.svh =====
// Assertion helpers for the IoU motion check block.
// The checks sample on the rising edge of clk; IOU_ASSERT also stays
// quiet while rst_n is low.
`ifndef IOU_MOTION_CHECK_UNIT_MACROS_SVH
`define IOU_MOTION_CHECK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define IOU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IOU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IOU_ASSERT(lbl, prop, msg)
`define IOU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/iou_pkg.sv =====
`default_nettype none

package iou_pkg;

    // defaults for the top-level parameters
    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths
    localparam int FIELD_W = 16;
    localparam int THR_W   = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

    // one pixel in Q12.4, added to intersection width and height
    localparam int INC_ONE = 16;

    // request and result codes
    localparam logic FUNC_BOX   = 1'b0;
    localparam logic FUNC_EOF   = 1'b1;
    localparam logic KIND_BOX   = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] obj_id;
        logic [FIELD_W-1:0] box_x;
        logic [FIELD_W-1:0] box_y;
        logic [FIELD_W-1:0] box_w;
        logic [FIELD_W-1:0] box_h;
    } iou_req_t;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] result_id;
        logic               moving;
        logic               frame_report;
    } iou_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AREA,
        ST_READ,
        ST_ENDS,
        ST_SPAN,
        ST_INTER,
        ST_UNION,
        ST_SCALE,
        ST_CMP,
        ST_DONE
    } iou_state_t;

    // datapath step selects
    typedef enum logic [2:0] {
        DP_NOP,
        DP_AREA,
        DP_ENDS,
        DP_SPAN,
        DP_INTER,
        DP_UNION,
        DP_SCALE
    } iou_dp_op_t;

    // datapath status back to the sequencer
    typedef struct packed {
        logic union_nonpos;
        logic inter_pos;
        logic ratio_above;
    } iou_dp_stat_t;

endpackage

`default_nettype wire

// ===== design/iou_motion_check_unit.sv =====
// IoU motion check.
// Request channel (req_valid/req_ready/req): one detection box per request,
// or an end-of-frame marker (func = 1). Result channel (rsp_valid/rsp_ready/
// rsp): exactly one result per request, in request order.
// A box is compared against each box stored from the previous frame by one
// shared multiplier under a small sequencer, which steps each stored box
// through read, ends, span, intersection, union, scale and compare; the
// scan stops at the first match and covers at most MAX_BOXES previous boxes.
// An end-of-frame request skips the scan and goes straight to its result.
// One request is in work at a time; the next is taken once the result has
// moved to the output register, so a new box can run while an old result
// waits. A stalled receiver holds the block only when a new result is ready
// and the output register is still full.
// End of frame flips the two banks of the box RAM (no copy), so the current
// frame becomes the previous one.
// Reset clears counts, frame flag and threshold (to 0.5); RAM contents are
// not cleared and need no clearing pass. The user must write the threshold
// via cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
`default_nettype none

`include "iou_motion_check_unit_macros.svh"

module iou_motion_check_unit #(
    parameter int MAX_BOXES  = iou_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = iou_pkg::COORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [iou_pkg::THR_W-1:0] cfg_wr_data,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire iou_pkg::iou_req_t         req,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output iou_pkg::iou_rsp_t              rsp
);

    import iou_pkg::*;

    localparam int C         = COORD_BITS;
    localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 * (1 << IDX_W);
    localparam int BOX_W     = 4 * C;
    localparam int REC_W     = 6 * C;

    iou_state_t        state_reg, state_next;
    iou_req_t          req_reg;
    logic [BOX_W-1:0]  box_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              matched_reg, matched_next;
    logic              bank_reg;
    logic [CNT_W-1:0]  cur_cnt_reg, prev_cnt_reg;
    logic              any_moving_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              rsp_valid_reg;
    iou_rsp_t          rsp_reg;

    logic              req_fire;
    logic              rsp_free;
    logic              done_fire;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [REC_W-1:0]  rd_rec;
    logic [2*C-1:0]    cur_area;
    logic              pair_match;
    logic              more_left;
    logic              cur_full;
    iou_dp_op_t        dp_op;
    iou_dp_stat_t      dp_stat;

    // handshake
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign done_fire = (state_reg == ST_DONE) && rsp_free;

    // match decision for the pair in the datapath
    assign pair_match = dp_stat.union_nonpos ? dp_stat.inter_pos : dp_stat.ratio_above;
    assign more_left  = ({1'b0, CNT_W'(idx_reg)} + (CNT_W+1)'(1)) < {1'b0, prev_cnt_reg};
    assign cur_full   = (cur_cnt_reg >= CNT_W'(MAX_BOXES));

    // RAM addressing: bank_reg holds the current frame
    assign rd_en   = (state_reg == ST_READ);
    assign rd_addr = {~bank_reg, idx_reg};
    assign wr_en   = done_fire && (req_reg.func == FUNC_BOX) && !cur_full;
    assign wr_addr = {bank_reg, cur_cnt_reg[IDX_W-1:0]};

    // sequencer: next state and datapath step
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        matched_next = matched_reg;
        dp_op        = DP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    idx_next     = '0;
                    matched_next = 1'b0;
                    state_next   = (req.func == FUNC_EOF) ? ST_DONE : ST_AREA;
                end
            end
            ST_AREA:
            begin
                dp_op      = DP_AREA;
                state_next = (prev_cnt_reg != '0) ? ST_READ : ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_ENDS;
            end
            ST_ENDS:
            begin
                dp_op      = DP_ENDS;
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                dp_op      = DP_SPAN;
                state_next = ST_INTER;
            end
            ST_INTER:
            begin
                dp_op      = DP_INTER;
                state_next = ST_UNION;
            end
            ST_UNION:
            begin
                dp_op      = DP_UNION;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                dp_op      = DP_SCALE;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (pair_match)
                begin
                    matched_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (more_left)
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            matched_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            matched_reg <= matched_next;
        end
    end

    // capture request; coordinates taken at COORD_BITS
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
            box_reg <= {C'(req.box_x), C'(req.box_y), C'(req.box_w), C'(req.box_h)};
        end
    end

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // frame bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg       <= 1'b0;
            cur_cnt_reg    <= '0;
            prev_cnt_reg   <= '0;
            any_moving_reg <= 1'b0;
        end
        else if (done_fire)
        begin
            if (req_reg.func == FUNC_EOF)
            begin
                bank_reg       <= ~bank_reg;
                prev_cnt_reg   <= cur_cnt_reg;
                cur_cnt_reg    <= '0;
                any_moving_reg <= 1'b0;
            end
            else
            begin
                any_moving_reg <= any_moving_reg || !matched_reg;
                if (!cur_full)
                begin
                    cur_cnt_reg <= cur_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            if (req_reg.func == FUNC_EOF)
            begin
                rsp_reg.kind         <= KIND_FRAME;
                rsp_reg.result_id    <= '0;
                rsp_reg.moving       <= 1'b0;
                rsp_reg.frame_report <= any_moving_reg;
            end
            else
            begin
                rsp_reg.kind         <= KIND_BOX;
                rsp_reg.result_id    <= req_reg.obj_id;
                rsp_reg.moving       <= !matched_reg;
                rsp_reg.frame_report <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // box store, both frames
    iou_box_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (REC_W)
    ) u_box_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({box_reg, cur_area}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_rec)
    );

    // geometry and shared multiplier
    iou_pair_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_pair_dp (
        .clk      (clk),
        .op       (dp_op),
        .cur_box  (box_reg),
        .prev_rec (rd_rec),
        .thr      (thr_reg),
        .cur_area (cur_area),
        .stat     (dp_stat)
    );

    // checks
    `IOU_ASSERT_ALWAYS(a_reset_idle, (!rst_n) |=> ((state_reg == ST_IDLE) && !rsp_valid_reg), "not idle after reset")
    `IOU_ASSERT(a_cnt_bound, (cur_cnt_reg <= CNT_W'(MAX_BOXES)) && (prev_cnt_reg <= CNT_W'(MAX_BOXES)), "box count above store depth")
    `IOU_ASSERT(a_read_in_range, (state_reg == ST_READ) |-> ({1'b0, CNT_W'(idx_reg)} < {1'b0, prev_cnt_reg}), "scan reads past previous frame")
    `IOU_ASSERT(a_eof_swap, (done_fire && (req_reg.func == FUNC_EOF)) |=> ((cur_cnt_reg == '0) && !any_moving_reg && (bank_reg != $past(bank_reg))), "frame end did not swap banks")
    `IOU_ASSERT(a_match_needs_prev, (rsp_valid_reg && (rsp_reg.kind == KIND_BOX) && !rsp_reg.moving) |-> (prev_cnt_reg != '0), "match reported with empty previous frame")

endmodule

`default_nettype wire

// ===== design/iou_box_ram.sv =====
`default_nettype none

module iou_box_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // one registered read port, holds data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/iou_pair_dp.sv =====
`default_nettype none

module iou_pair_dp #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                      clk,
    input  wire iou_pkg::iou_dp_op_t       op,
    input  wire logic [4*COORD_BITS-1:0]   cur_box,
    input  wire logic [6*COORD_BITS-1:0]   prev_rec,
    input  wire logic [iou_pkg::THR_W-1:0] thr,
    output logic      [2*COORD_BITS-1:0]   cur_area,
    output iou_pkg::iou_dp_stat_t          stat
);

    import iou_pkg::*;

    localparam int C       = COORD_BITS;
    localparam int END_W   = C + 1;
    localparam int SPAN_W  = C + 2;
    localparam int SSPAN_W = C + 3;
    localparam int AREA_W  = 2 * C;
    localparam int INTER_W = 2 * SPAN_W;
    localparam int UNI_W   = 2 * C + 1;
    localparam int USUM_W  = INTER_W + 2;
    localparam int MA_W    = UNI_W;
    localparam int MB_W    = (SPAN_W > THR_W) ? SPAN_W : THR_W;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int RHS_W   = UNI_W + THR_W;
    localparam int CMP_W   = INTER_W + THR_W;

    logic [C-1:0]       cx, cy, cw, ch;
    logic [C-1:0]       px, py, pw, ph;
    logic [AREA_W-1:0]  parea;
    logic [END_W-1:0]   cx_end, cy_end, px_end, py_end;
    logic [C-1:0]       x1_reg, y1_reg;
    logic [END_W-1:0]   x2_reg, y2_reg;
    logic [SSPAN_W-1:0] sx, sy;
    logic [SPAN_W-1:0]  iw_reg, ih_reg;
    logic [MA_W-1:0]    mul_a;
    logic [MB_W-1:0]    mul_b;
    logic [PROD_W-1:0]  prod;
    logic [AREA_W-1:0]  area_reg;
    logic [INTER_W-1:0] inter_reg;
    logic [USUM_W-1:0]  usum;
    logic [UNI_W-1:0]   uni_reg;
    logic               nonpos_reg;
    logic [RHS_W-1:0]   rhs_reg;

    // field unpack
    assign cx    = cur_box[4*C-1:3*C];
    assign cy    = cur_box[3*C-1:2*C];
    assign cw    = cur_box[2*C-1:C];
    assign ch    = cur_box[C-1:0];
    assign px    = prev_rec[6*C-1:5*C];
    assign py    = prev_rec[5*C-1:4*C];
    assign pw    = prev_rec[4*C-1:3*C];
    assign ph    = prev_rec[3*C-1:2*C];
    assign parea = prev_rec[2*C-1:0];

    // right and bottom edges
    assign cx_end = END_W'(cx) + END_W'(cw);
    assign cy_end = END_W'(cy) + END_W'(ch);
    assign px_end = END_W'(px) + END_W'(pw);
    assign py_end = END_W'(py) + END_W'(ph);

    // overlap span plus one pixel, clamped at zero
    assign sx = SSPAN_W'(x2_reg) - SSPAN_W'(x1_reg) + SSPAN_W'(INC_ONE);
    assign sy = SSPAN_W'(y2_reg) - SSPAN_W'(y1_reg) + SSPAN_W'(INC_ONE);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            DP_AREA:
            begin
                mul_a = MA_W'(cw);
                mul_b = MB_W'(ch);
            end
            DP_INTER:
            begin
                mul_a = MA_W'(iw_reg);
                mul_b = MB_W'(ih_reg);
            end
            DP_SCALE:
            begin
                mul_a = uni_reg;
                mul_b = MB_W'(thr);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // union = both areas minus intersection, signed
    assign usum = USUM_W'(area_reg) + USUM_W'(parea) - USUM_W'(inter_reg);

    // step registers
    always_ff @(posedge clk)
    begin
        case (op)
            DP_AREA:
            begin
                area_reg <= prod[AREA_W-1:0];
            end
            DP_ENDS:
            begin
                x1_reg <= (px > cx) ? px : cx;
                y1_reg <= (py > cy) ? py : cy;
                x2_reg <= (px_end < cx_end) ? px_end : cx_end;
                y2_reg <= (py_end < cy_end) ? py_end : cy_end;
            end
            DP_SPAN:
            begin
                iw_reg <= sx[SSPAN_W-1] ? '0 : sx[SPAN_W-1:0];
                ih_reg <= sy[SSPAN_W-1] ? '0 : sy[SPAN_W-1:0];
            end
            DP_INTER:
            begin
                inter_reg <= prod[INTER_W-1:0];
            end
            DP_UNION:
            begin
                uni_reg    <= usum[UNI_W-1:0];
                nonpos_reg <= usum[USUM_W-1] || (usum == '0);
            end
            DP_SCALE:
            begin
                rhs_reg <= prod[RHS_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // inter * 65536 against thr * union
    assign stat.union_nonpos = nonpos_reg;
    assign stat.inter_pos    = (inter_reg != '0);
    assign stat.ratio_above  = ({inter_reg, {THR_W{1'b0}}} > CMP_W'(rhs_reg));

    assign cur_area = area_reg;

endmodule

`default_nettype wire
